### rtl/core/qkd_pkg.sv
`default_nettype none

package qkd_pkg;

  // key layout
  localparam int KEY_W      = 40;
  localparam int CODE_W     = 12;
  localparam int SQ_W       = 23;
  localparam int FIELD_W    = 16;
  localparam int NUM_COMP   = 4;
  localparam int NUM_CODE   = 3;

  localparam logic [CODE_W-1:0] CODE_CENTER = 12'd2048;

  // one in Q23 and 0.001 in Q33
  localparam logic [24:0] ONE_Q23 = 25'd8388608;
  localparam logic [36:0] EPS_Q33 = 37'd8589935;

  // omitted-component codes
  localparam logic [1:0] OMIT_X = 2'd0;
  localparam logic [1:0] OMIT_Y = 2'd1;
  localparam logic [1:0] OMIT_Z = 2'd2;
  localparam logic [1:0] OMIT_W = 2'd3;

  localparam logic [3:0] OMIT_MAX = 4'd3;

  // side information that travels alongside the root lanes
  typedef struct packed {
    logic [NUM_COMP-1:0] neg;
    logic [1:0]          omit;
    logic                bad;
  } qkd_meta_t;

endpackage

`default_nettype wire

### rtl/core/quaternion_key_decompress.sv
`default_nettype none

// channel    | ports                            | handshake
// -----------+----------------------------------+------------------------------
// key in     | packed_key                       | start, taken when busy is low
// result out | comp_x comp_y comp_z comp_w      | done, one cycle, no stall
//            | bad_key                          |
//
// a new key may be started in every cycle; busy stays low
// each transaction passes through the registered stages in order
// (decode, radicand, FRAC_BITS+2 root cells, rounding)
// results leave in start order; the receiver cannot stall, so nothing waits
// synchronous active-high rst clears all valid flags in the chain

module quaternion_key_decompress #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [qkd_pkg::KEY_W-1:0]     packed_key,
  output logic                               done,
  output logic signed [qkd_pkg::FIELD_W-1:0] comp_x,
  output logic signed [qkd_pkg::FIELD_W-1:0] comp_y,
  output logic signed [qkd_pkg::FIELD_W-1:0] comp_z,
  output logic signed [qkd_pkg::FIELD_W-1:0] comp_w,
  output logic                               bad_key
);
  import qkd_pkg::*;

  localparam int RTW = FRAC_BITS + 2;   // root bits, one per cell
  localparam int RW  = 2 * RTW;         // radicand bits
  localparam int MW  = (RTW > FIELD_W) ? RTW : FIELD_W;
  localparam int LAT = RTW + 3;

  // every key is independent, so the chain never pushes back
  assign busy = 1'b0;

  // chain taps: index 0 is the front end, index RTW the last cell
  logic                 ch_valid [RTW+1];
  qkd_meta_t            ch_meta  [RTW+1];
  logic [3:0][RW-1:0]   ch_rad   [RTW+1];
  logic [3:0][RTW+1:0]  ch_rem   [RTW+1];
  logic [3:0][RTW-1:0]  ch_root  [RTW+1];

  // decode of the three codes, their squares, and radicands of all four components
  qkd_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .packed_key(packed_key),
    .out_valid (ch_valid[0]),
    .out_meta  (ch_meta[0]),
    .out_rad   (ch_rad[0])
  );

  // first cell starts from an empty remainder and root
  assign ch_rem[0]  = '0;
  assign ch_root[0] = '0;

  // row of root cells, each settling one bit of all four roots
  for (genvar g = 0; g < RTW; g++) begin : g_cell
    qkd_root_cell #(
      .RTW(RTW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (ch_valid[g]),
      .in_meta  (ch_meta[g]),
      .in_rad   (ch_rad[g]),
      .in_rem   (ch_rem[g]),
      .in_root  (ch_root[g]),
      .out_valid(ch_valid[g+1]),
      .out_meta (ch_meta[g+1]),
      .out_rad  (ch_rad[g+1]),
      .out_rem  (ch_rem[g+1]),
      .out_root (ch_root[g+1])
    );
  end

  // rounding: the root carries one extra fraction bit, halve with round-up
  logic [3:0][FIELD_W-1:0] field_next;

  always_comb begin
    logic [RTW:0]  rnd;
    logic [MW-1:0] mag;
    logic [MW-1:0] val;
    for (int c = 0; c < NUM_COMP; c++) begin
      rnd = (RTW+1)'(ch_root[RTW][c]) + (RTW+1)'(1);
      mag = MW'(rnd[RTW:1]);
      val = ch_meta[RTW].neg[c] ? (MW'(0) - mag) : mag;
      // a bad key forces all components to zero
      field_next[c] = ch_meta[RTW].bad ? '0 : val[FIELD_W-1:0];
    end
  end

  // result register, one strobe per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ch_valid[RTW];
    end
    comp_x  <= field_next[0];
    comp_y  <= field_next[1];
    comp_z  <= field_next[2];
    comp_w  <= field_next[3];
    bad_key <= ch_meta[RTW].bad;
  end

  // fixed latency from start to result
  assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("result missing after fixed latency");

  assert property (@(posedge clk) disable iff (rst)
    (done && bad_key) |-> (comp_x == 0) && (comp_y == 0) &&
                          (comp_z == 0) && (comp_w == 0))
    else $error("bad key with non-zero components");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ch_valid[RTW]))
    else $error("result strobe without a transaction in the chain");

endmodule

`default_nettype wire

### rtl/core/qkd_front.sv
`default_nettype none

module qkd_front #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic [qkd_pkg::KEY_W-1:0]          packed_key,
  output logic                                    out_valid,
  output qkd_pkg::qkd_meta_t                      out_meta,
  output logic [3:0][2*(FRAC_BITS+2)-1:0]         out_rad
);
  import qkd_pkg::*;

  localparam int RTW  = FRAC_BITS + 2;
  localparam int RW   = 2 * RTW;
  localparam int XW   = 2 * FRAC_BITS + 40;
  // scaling of a present square (Q23) and the omitted radicand (Q33)
  localparam int P_E  = 2 * FRAC_BITS - 21;
  localparam int P_L  = (P_E > 0) ? P_E : 0;
  localparam int P_R  = (P_E < 0) ? -P_E : 0;
  localparam int O_E  = 2 * FRAC_BITS - 31;
  localparam int O_L  = (O_E > 0) ? O_E : 0;
  localparam int O_R  = (O_E < 0) ? -O_E : 0;

  // decode stage
  logic                     dec_valid;
  logic [NUM_CODE-1:0]      dec_neg;
  logic [NUM_CODE-1:0][SQ_W-1:0] dec_sq;
  logic [1:0]               dec_omit;
  logic                     dec_bad;

  logic [NUM_CODE-1:0][CODE_W-1:0] code;
  logic [NUM_CODE-1:0][CODE_W-1:0] mag;
  logic [NUM_CODE-1:0]             neg_c;

  always_comb begin
    code[0] = {packed_key[3:0], packed_key[39:32]};
    code[1] = packed_key[31:20];
    code[2] = packed_key[19:8];
    for (int i = 0; i < NUM_CODE; i++) begin
      neg_c[i] = (code[i] < CODE_CENTER);
      mag[i]   = neg_c[i] ? (CODE_CENTER - code[i]) : (code[i] - CODE_CENTER);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_valid;
    end
    for (int i = 0; i < NUM_CODE; i++) begin
      dec_sq[i] <= SQ_W'(mag[i] * mag[i]);
    end
    dec_neg  <= neg_c;
    dec_omit <= packed_key[5:4];
    dec_bad  <= (packed_key[7:4] > OMIT_MAX);
  end

  // radicand stage
  logic [24:0]              sum_sq;
  logic signed [36:0]       rad_raw;
  logic [33:0]              rad_omit;
  logic [XW-1:0]            omit_scaled;
  logic [NUM_CODE-1:0][RW-1:0] pres_scaled;
  logic [3:0][RW-1:0]       rad_next;
  qkd_meta_t                meta_next;

  always_comb begin
    logic [1:0] idx;
    logic [XW-1:0] tmp;
    sum_sq  = 25'(dec_sq[0]) + 25'(dec_sq[1]) + 25'(dec_sq[2]);
    rad_raw = $signed({1'b0, 36'(ONE_Q23)}) - $signed({1'b0, 36'(sum_sq)});
    rad_raw = rad_raw <<< 10;
    if (dec_omit == OMIT_Z) begin
      rad_raw = rad_raw + $signed(EPS_Q33);
    end
    rad_omit    = rad_raw[36] ? '0 : rad_raw[33:0];
    omit_scaled = (XW'(rad_omit) << O_L) >> O_R;
    for (int i = 0; i < NUM_CODE; i++) begin
      tmp            = (XW'(dec_sq[i]) << P_L) >> P_R;
      pres_scaled[i] = tmp[RW-1:0];
    end
    meta_next.omit = dec_omit;
    meta_next.bad  = dec_bad;
    for (int c = 0; c < NUM_COMP; c++) begin
      idx = (c < int'(dec_omit)) ? 2'(c) : 2'(c - 1);
      if (c == int'(dec_omit)) begin
        rad_next[c]      = omit_scaled[RW-1:0];
        meta_next.neg[c] = 1'b0;
      end else begin
        rad_next[c]      = pres_scaled[idx];
        meta_next.neg[c] = dec_neg[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dec_valid;
    end
    out_rad  <= rad_next;
    out_meta <= meta_next;
  end

  // omitted lane never carries a sign
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_meta.neg[out_meta.omit])
    else $error("omitted component marked negative");

endmodule

`default_nettype wire

### rtl/core/qkd_root_cell.sv
`default_nettype none

module qkd_root_cell #(
  parameter int RTW = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire qkd_pkg::qkd_meta_t         in_meta,
  input  wire logic [3:0][2*RTW-1:0]      in_rad,
  input  wire logic [3:0][RTW+1:0]        in_rem,
  input  wire logic [3:0][RTW-1:0]        in_root,
  output logic                            out_valid,
  output qkd_pkg::qkd_meta_t              out_meta,
  output logic [3:0][2*RTW-1:0]           out_rad,
  output logic [3:0][RTW+1:0]             out_rem,
  output logic [3:0][RTW-1:0]             out_root
);
  import qkd_pkg::*;

  localparam int RW = 2 * RTW;

  logic [3:0][RW-1:0]  rad_next;
  logic [3:0][RTW+1:0] rem_next;
  logic [3:0][RTW-1:0] root_next;

  // one result bit per lane: bring down two radicand bits, try 4r+1
  always_comb begin
    logic [RTW+3:0] acc;
    logic [RTW+3:0] trial;
    for (int l = 0; l < 4; l++) begin
      acc   = {in_rem[l], in_rad[l][RW-1 -: 2]};
      trial = {2'b00, in_root[l], 2'b01};
      if (acc >= trial) begin
        rem_next[l]  = (RTW+2)'(acc - trial);
        root_next[l] = {in_root[l][RTW-2:0], 1'b1};
      end else begin
        rem_next[l]  = acc[RTW+1:0];
        root_next[l] = {in_root[l][RTW-2:0], 1'b0};
      end
      rad_next[l] = {in_rad[l][RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_meta <= in_meta;
    out_rad  <= rad_next;
    out_rem  <= rem_next;
    out_root <= root_next;
  end

  // remainder of a digit-by-digit root never exceeds twice the root
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((RTW+2)'(out_rem[0]) <= {1'b0, out_root[0], 1'b0}) &&
                  ((RTW+2)'(out_rem[1]) <= {1'b0, out_root[1], 1'b0}) &&
                  ((RTW+2)'(out_rem[2]) <= {1'b0, out_root[2], 1'b0}) &&
                  ((RTW+2)'(out_rem[3]) <= {1'b0, out_root[3], 1'b0}))
    else $error("root remainder out of range");

  assert property (@(posedge clk) disable iff (rst)
    in_valid |=> out_valid && (out_meta == $past(in_meta)))
    else $error("side information lost in root cell");

endmodule

`default_nettype wire
